/* rtl/b2r_pkg.sv */
// shared types, codes and lookup functions for the binary to roman numeral block
// no dependencies; imported by the interfaces, controller, datapath and top level
package b2r_pkg;

    localparam int unsigned ValueW  = 12;
    localparam int unsigned SymbolW = 8;
    localparam int unsigned StatusW = 2;
    localparam int unsigned DigitW  = 4;
    localparam int unsigned PosW    = 2;
    localparam int unsigned IdxW    = 2;
    localparam int unsigned LenW    = 3;
    localparam int unsigned StepW   = 14;

    localparam logic [ValueW-1:0] ValueLimit = ValueW'(3999);

    // status codes of a result word
    localparam logic [StatusW-1:0] ST_CHAR  = 2'd0;
    localparam logic [StatusW-1:0] ST_ZERO  = 2'd1;
    localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

    localparam logic [SymbolW-1:0] SymI = 8'h49;
    localparam logic [SymbolW-1:0] SymV = 8'h56;
    localparam logic [SymbolW-1:0] SymX = 8'h58;
    localparam logic [SymbolW-1:0] SymL = 8'h4c;
    localparam logic [SymbolW-1:0] SymC = 8'h43;
    localparam logic [SymbolW-1:0] SymD = 8'h44;
    localparam logic [SymbolW-1:0] SymM = 8'h4d;
    localparam logic [SymbolW-1:0] SymNone = 8'h00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_EMIT,
        S_FLAG
    } t_state;

    typedef enum logic [1:0] {
        K_ONE,
        K_FIVE,
        K_TEN
    } t_kind;

    typedef struct packed {
        logic load;
        logic split;
        logic skip;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic flag;
        logic pos_zero;
        logic dig_empty;
        logic run_end;
    } t_dp_sts;

    // place weight times k, for the digit compare thresholds
    function automatic logic [StepW-1:0] f_step(input logic [PosW-1:0] pos,
                                                input logic [DigitW-1:0] k);
        logic [StepW-1:0] weight;
        unique case (pos)
            2'd0:    weight = StepW'(1);
            2'd1:    weight = StepW'(10);
            2'd2:    weight = StepW'(100);
            default: weight = StepW'(1000);
        endcase
        return weight * StepW'(k);
    endfunction

    // number of characters a decimal digit takes
    function automatic logic [LenW-1:0] f_len(input logic [DigitW-1:0] d);
        logic [LenW-1:0] len;
        case (d)
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4 - 3'd0;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    // which of one, five, ten sits at a given place in a digit's run
    function automatic t_kind f_kind(input logic [DigitW-1:0] d,
                                     input logic [IdxW-1:0] idx);
        t_kind kind;
        case (d)
            4'd4:    kind = (idx == 2'd0) ? K_ONE : K_FIVE;
            4'd9:    kind = (idx == 2'd0) ? K_ONE : K_TEN;
            4'd5, 4'd6, 4'd7,
            4'd8:    kind = (idx == 2'd0) ? K_FIVE : K_ONE;
            default: kind = K_ONE;
        endcase
        return kind;
    endfunction

    function automatic logic [SymbolW-1:0] f_sym(input logic [PosW-1:0] pos,
                                                 input t_kind kind);
        logic [SymbolW-1:0] sym;
        sym = SymNone;
        unique case (pos)
            2'd0: begin
                case (kind)
                    K_ONE:   sym = SymI;
                    K_FIVE:  sym = SymV;
                    default: sym = SymX;
                endcase
            end
            2'd1: begin
                case (kind)
                    K_ONE:   sym = SymX;
                    K_FIVE:  sym = SymL;
                    default: sym = SymC;
                endcase
            end
            2'd2: begin
                case (kind)
                    K_ONE:   sym = SymC;
                    K_FIVE:  sym = SymD;
                    default: sym = SymM;
                endcase
            end
            default: begin
                sym = (kind == K_ONE) ? SymM : SymNone;
            end
        endcase
        return sym;
    endfunction

endpackage

/* rtl/b2r_if.sv */
// valid/ready channel interfaces for the value input and the numeral output
// depends on b2r_pkg for the field widths
interface b2r_in_if import b2r_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2r_out_if import b2r_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SymbolW-1:0] symbol;
    logic [StatusW-1:0] status;
    logic               last;

    modport source (output valid, output symbol, output status, output last, input ready);
    modport sink   (input valid, input symbol, input status, input last, output ready);
endinterface

/* rtl/b2r_ctrl.sv */
// sequencing state machine: load, digit split, character emission, flag word
// depends on b2r_pkg for the state enum and the command/status structs
module b2r_ctrl import b2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_sts.flag) begin
                    n_state = S_FLAG;
                end else if (i_sts.pos_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.dig_empty && i_out_ready && i_sts.run_end) n_state = S_IDLE;
            end
            S_FLAG: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SPLIT: begin
                o_cmd.split = !i_sts.flag;
            end
            S_EMIT: begin
                // zero digits ahead of the last nonzero one are skipped with no word
                o_cmd.skip    = i_sts.dig_empty;
                o_out_valid   = !i_sts.dig_empty;
                o_cmd.advance = !i_sts.dig_empty && i_out_ready;
            end
            S_FLAG: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a word is on offer");

    a_flag_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLAG && i_out_ready) |=> o_in_ready)
        else $error("flag word not followed by a free block");

    a_split_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.split && i_sts.pos_zero) |=> (r_state == S_EMIT && !i_sts.flag))
        else $error("split did not hand over to emission");

endmodule

/* rtl/b2r_dp.sv */
// datapath: value register, one-digit-a-cycle decimal split, digit store, symbol lookup
// depends on b2r_pkg for widths, codes and lookup functions
module b2r_dp import b2r_pkg::*; (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [ValueW-1:0]  i_value,
    output logic [SymbolW-1:0] o_symbol,
    output logic [StatusW-1:0] o_status,
    output logic               o_last
);

    logic [ValueW-1:0] r_rem;
    logic [ValueW-1:0] n_rem;
    logic [DigitW-1:0] r_digit [4];
    logic [PosW-1:0]   r_pos;
    logic [IdxW-1:0]   r_idx;
    logic              r_zero;
    logic              r_range;

    logic [DigitW-1:0] w_digit;
    logic [StepW-1:0]  w_sub;
    logic [DigitW-1:0] w_cur;
    logic [LenW-1:0]   w_len;
    logic              w_dig_end;
    logic              w_lower_nz;
    t_kind             w_kind;

    // digit at the current place: highest multiple of the weight not above the remainder
    always_comb begin
        w_digit = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rem} >= f_step(r_pos, DigitW'(k))) w_digit = DigitW'(k);
        end
        w_sub = f_step(r_pos, w_digit);
        n_rem = r_rem - w_sub[ValueW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_value;
            r_zero  <= (i_value == '0);
            r_range <= (i_value > ValueLimit);
            r_pos   <= 2'd3;
        end else if (i_cmd.split) begin
            r_digit[r_pos] <= w_digit;
            r_rem          <= n_rem;
            r_pos          <= r_pos - 2'd1;
            r_idx          <= '0;
        end else if (i_cmd.skip || (i_cmd.advance && w_dig_end)) begin
            r_pos <= r_pos - 2'd1;
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    assign w_cur     = r_digit[r_pos];
    assign w_len     = f_len(w_cur);
    assign w_dig_end = ((LenW'(r_idx) + 3'd1) == w_len);
    assign w_kind    = f_kind(w_cur, r_idx);

    // any nonzero digit below the current place means more words follow
    always_comb begin
        w_lower_nz = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (PosW'(k) < r_pos && r_digit[k] != '0) w_lower_nz = 1'b1;
        end
    end

    assign o_sts.flag      = r_zero || r_range;
    assign o_sts.pos_zero  = (r_pos == 2'd0);
    assign o_sts.dig_empty = (w_len == '0);
    assign o_sts.run_end   = w_dig_end && !w_lower_nz;

    always_comb begin
        if (r_range) begin
            o_symbol = SymNone;
            o_status = ST_RANGE;
            o_last   = 1'b1;
        end else if (r_zero) begin
            o_symbol = SymNone;
            o_status = ST_ZERO;
            o_last   = 1'b1;
        end else begin
            o_symbol = f_sym(r_pos, w_kind);
            o_status = ST_CHAR;
            o_last   = o_sts.run_end;
        end
    end

    a_digit_decimal: assert property (@(posedge i_clk)
        i_cmd.split |-> (w_digit <= 4'd9))
        else $error("split produced a digit above nine");

    a_rem_below_weight: assert property (@(posedge i_clk)
        i_cmd.split |-> ({2'b00, n_rem} < f_step(r_pos, 4'd1)))
        else $error("remainder not below the place weight after split");

endmodule

/* rtl/binary_to_roman_numeral_top.sv */
// Converts a 12-bit unsigned value into its Roman numeral, one ASCII character per
// output word, most significant first, with the final word marked by last. Zero gives a
// single empty word and values above 3999 a single out-of-range word. Any other item is
// loaded, then split into its four decimal digits (one digit per cycle through a shared
// compare-and-subtract unit); each zero digit ahead of the last nonzero one is skipped
// with no word, then the characters follow at one per cycle while the output is ready. A
// new value is taken only once the previous run has been delivered.
module binary_to_roman_numeral_top import b2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b2r_in_if.sink      i_in,
    b2r_out_if.source   o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    b2r_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    b2r_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_value  (i_in.value),
        .o_symbol (o_out.symbol),
        .o_status (o_out.status),
        .o_last   (o_out.last)
    );

endmodule

/* tb/sv/tb_binary_to_roman_numeral_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for binary_to_roman_numeral_top: directed table then random values
// depends on b2r_pkg, b2r_in_if / b2r_out_if and the top level from the rtl folder
module tb_binary_to_roman_numeral_top;
    import b2r_pkg::*;

    localparam int NumDirected = 25;
    localparam int NumRandom   = 145;

    typedef struct packed {
        logic [SymbolW-1:0] symbol;
        logic [StatusW-1:0] status;
        logic               last;
    } t_numeral_word;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              typed;
        t_numeral_word     word;
    } t_stim_row;

    // typed rows give their single word outright, the rest go through the predictor
    t_stim_row directed_rows [NumDirected] = '{
        '{12'd0,    1'b1, '{SymNone, ST_ZERO,  1'b1}},
        '{12'd1,    1'b1, '{SymI,    ST_CHAR,  1'b1}},
        '{12'd5,    1'b1, '{SymV,    ST_CHAR,  1'b1}},
        '{12'd10,   1'b1, '{SymX,    ST_CHAR,  1'b1}},
        '{12'd1000, 1'b1, '{SymM,    ST_CHAR,  1'b1}},
        '{12'd3999, 1'b0, '0},
        '{12'd4000, 1'b1, '{SymNone, ST_RANGE, 1'b1}},
        '{12'd4095, 1'b1, '{SymNone, ST_RANGE, 1'b1}},
        '{12'd3888, 1'b0, '0},
        '{12'd4,    1'b0, '0},
        '{12'd9,    1'b0, '0},
        '{12'd14,   1'b0, '0},
        '{12'd40,   1'b0, '0},
        '{12'd49,   1'b0, '0},
        '{12'd50,   1'b1, '{SymL,    ST_CHAR,  1'b1}},
        '{12'd90,   1'b0, '0},
        '{12'd99,   1'b0, '0},
        '{12'd100,  1'b1, '{SymC,    ST_CHAR,  1'b1}},
        '{12'd400,  1'b0, '0},
        '{12'd444,  1'b0, '0},
        '{12'd500,  1'b1, '{SymD,    ST_CHAR,  1'b1}},
        '{12'd999,  1'b0, '0},
        '{12'd2048, 1'b0, '0},
        '{12'd1365, 1'b0, '0},
        '{12'd2730, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    t_numeral_word pending_words [$];
    t_numeral_word exp_word;
    int            mismatch_count = 0;
    int            tx_calm = 0;
    int            rx_calm = 0;
    int            rx_stall = 0;

    b2r_in_if  in_ch ();
    b2r_out_if out_ch ();

    binary_to_roman_numeral_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 clk = ~clk;

    function automatic void push_word(input logic [SymbolW-1:0] sym,
                                      input logic [StatusW-1:0] st,
                                      input logic               lst);
        t_numeral_word w;
        w.symbol = sym;
        w.status = st;
        w.last   = lst;
        pending_words.push_back(w);
    endfunction

    // roman spelling of one value, appended to the words still owed
    function automatic void spell_numeral(input logic [ValueW-1:0] v);
        int unsigned        rest;
        int unsigned        scale;
        int unsigned        digit;
        logic [SymbolW-1:0] one_sym;
        logic [SymbolW-1:0] five_sym;
        logic [SymbolW-1:0] ten_sym;
        if (v > ValueLimit) begin
            push_word(SymNone, ST_RANGE, 1'b1);
            return;
        end
        if (v == '0) begin
            push_word(SymNone, ST_ZERO, 1'b1);
            return;
        end
        rest  = v;
        scale = 1000;
        for (int place = 3; place >= 0; place--) begin
            digit = rest / scale;
            rest  = rest % scale;
            scale = scale / 10;
            case (place)
                3: begin
                    one_sym = SymM; five_sym = SymNone; ten_sym = SymNone;
                end
                2: begin
                    one_sym = SymC; five_sym = SymD; ten_sym = SymM;
                end
                1: begin
                    one_sym = SymX; five_sym = SymL; ten_sym = SymC;
                end
                default: begin
                    one_sym = SymI; five_sym = SymV; ten_sym = SymX;
                end
            endcase
            if (digit == 9) begin
                push_word(one_sym, ST_CHAR, 1'b0);
                push_word(ten_sym, ST_CHAR, 1'b0);
            end else if (digit == 4) begin
                push_word(one_sym, ST_CHAR, 1'b0);
                push_word(five_sym, ST_CHAR, 1'b0);
            end else begin
                if (digit >= 5) begin
                    push_word(five_sym, ST_CHAR, 1'b0);
                    digit -= 5;
                end
                repeat (digit) push_word(one_sym, ST_CHAR, 1'b0);
            end
        end
        pending_words[pending_words.size()-1].last = 1'b1;
    endfunction

    // mostly no gap, some short, a few long, with calm stretches now and then
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 3) begin
            calm = $urandom_range(40, 15);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // digits that give long runs or subtractive pairs
    function automatic int unsigned heavy_digit();
        case ($urandom_range(4, 0))
            0:       return 3;
            1:       return 4;
            2:       return 7;
            3:       return 8;
            default: return 9;
        endcase
    endfunction

    function automatic logic [ValueW-1:0] pick_value();
        int r;
        r = $urandom_range(99, 0);
        if (r < 4) return '0;
        if (r < 12) return ValueW'($urandom_range(4095, 4000));
        if (r < 24) return ValueW'($urandom_range(3, 0) * 1000 + heavy_digit() * 100
                                   + heavy_digit() * 10 + heavy_digit());
        return ValueW'($urandom_range(3999, 1));
    endfunction

    // entered and left at a falling edge
    task automatic send_value(input t_stim_row row);
        int gap;
        gap = pick_idle(tx_calm);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            in_ch.value = ValueW'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = row.value;
        do @(posedge clk); while (!in_ch.ready);
        if (row.typed) pending_words.push_back(row.word);
        else spell_numeral(row.value);
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input int unsigned expected,
                                        input int unsigned actual);
        if (expected != actual) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name,
                     expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t ns: unexpected word, symbol %0h status %0d last %0b",
                         $time, out_ch.symbol, out_ch.status, out_ch.last);
                mismatch_count++;
            end else begin
                exp_word = pending_words.pop_front();
                check_field("symbol", exp_word.symbol, out_ch.symbol);
                check_field("status", exp_word.status, out_ch.status);
                check_field("last", exp_word.last, out_ch.last);
            end
        end
    end

    // output side back-pressure
    initial begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_stall > 0) begin
                out_ch.ready = 1'b0;
                rx_stall--;
            end else begin
                out_ch.ready = 1'b1;
                rx_stall = pick_idle(rx_calm);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout, %0d words still owed", pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_stim_row row;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) send_value(directed_rows[i]);

        row.typed = 1'b0;
        row.word  = '0;
        repeat (NumRandom) begin
            row.value = pick_value();
            send_value(row);
        end
        in_ch.valid = 1'b0;

        while (pending_words.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
